@@ hdl/ccs_pkg.sv @@
package ccs_pkg;

    localparam int COL_W           = 64;
    localparam int LANE_W          = 8;
    localparam int LANES           = COL_W / LANE_W;
    localparam int LANE_IDX_W      = $clog2(LANE_W);
    localparam int LANE_SEL_W      = $clog2(LANES);
    localparam int BOX_COL_W       = 12;
    localparam int ROW_W           = 6;
    localparam int CFG_W           = 7;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLUMNS = 4096;

    localparam logic [CFG_W-1:0] ROWS_USED_RESET = 7'd64;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_ROWS_USED = 1'b0;

    typedef struct packed {
        logic [COL_W-1:0] col_bits;
        logic             line_end;
    } in_item_t;

    typedef struct packed {
        logic [BOX_COL_W-1:0] box_start;
        logic [BOX_COL_W-1:0] box_end;
        logic [ROW_W-1:0]     box_top;
        logic [ROW_W-1:0]     box_bottom;
        logic                 run_last;
    } out_item_t;

    typedef struct packed {
        logic                  any;
        logic                  link;
        logic [LANE_IDX_W-1:0] lo;
        logic [LANE_IDX_W-1:0] hi;
    } lane_res_t;

endpackage

@@ hdl/ccs_lane.sv @@
module ccs_lane
    import ccs_pkg::*;
(
    input  logic [LANE_W-1:0] col_seg,
    input  logic [LANE_W-1:0] prev_seg,
    input  logic              col_below,
    input  logic              col_above,
    output lane_res_t         res
);

    logic [LANE_W+1:0] ext;
    logic [LANE_W-1:0] near;

    assign ext  = {col_above, col_seg, col_below};

    always_comb begin
        for (int r = 0; r < LANE_W; r++) begin
            near[r] = ext[r] | ext[r+1] | ext[r+2];
        end
    end

    always_comb begin
        res.any  = |col_seg;
        res.link = |(prev_seg & near);
        res.lo   = '0;
        res.hi   = '0;
        // Scanning downward leaves the lowest set row in lo.
        for (int r = LANE_W - 1; r >= 0; r--) begin
            if (col_seg[r]) begin
                res.lo = LANE_IDX_W'(r);
            end
        end
        for (int r = 0; r < LANE_W; r++) begin
            if (col_seg[r]) begin
                res.hi = LANE_IDX_W'(r);
            end
        end
    end

endmodule

@@ hdl/ccs_ctrl.sv @@
module ccs_ctrl
    import ccs_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             line_end,
    input  logic [COL_W-1:0] col,
    input  lane_res_t        lane_res [LANES],
    output logic [COL_W-1:0] prev_col,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    localparam int CNT_W   = $clog2(MAX_COLUMNS);
    localparam int DEPTH   = 4;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int QCNT_W  = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0]  LAST_COL = CNT_W'(MAX_COLUMNS - 1);
    localparam logic [QCNT_W-1:0] ROOM_MAX = QCNT_W'(DEPTH - 2);

    function automatic logic [BOX_COL_W-1:0] to_box_col(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[BOX_COL_W-1:0];
    endfunction

    logic              open_reg,  open_next;
    logic [CNT_W-1:0]  start_reg, start_next;
    logic [ROW_W-1:0]  top_reg,   top_next;
    logic [ROW_W-1:0]  bot_reg,   bot_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [COL_W-1:0]  prev_reg,  prev_next;

    out_item_t         queue_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [QCNT_W-1:0] qcnt_reg, qcnt_next;

    logic              in_fire, m_fire;
    logic              link, any, end_col, brk, cont, open_mid;
    logic [ROW_W-1:0]  t_row, b_row, top_mid, bot_mid;
    logic [CNT_W-1:0]  start_mid;
    out_item_t         box_brk, box_end;
    out_item_t         e0, e1;
    logic [1:0]        n_push;

    assign in_fire  = in_valid && in_ready;
    assign m_fire   = m_valid && m_ready;
    assign in_ready = qcnt_reg <= ROOM_MAX;
    assign m_valid  = qcnt_reg != '0;
    assign m_data   = queue_reg[rptr_reg];
    assign prev_col = prev_reg;

    // Merge the lane findings: any black pixel, any link, extreme rows.
    always_comb begin
        link  = 1'b0;
        any   = 1'b0;
        t_row = '0;
        b_row = '0;
        for (int i = 0; i < LANES; i++) begin
            link = link | lane_res[i].link;
            any  = any  | lane_res[i].any;
        end
        for (int i = LANES - 1; i >= 0; i--) begin
            if (lane_res[i].any) begin
                t_row = {LANE_SEL_W'(i), lane_res[i].lo};
            end
        end
        for (int i = 0; i < LANES; i++) begin
            if (lane_res[i].any) begin
                b_row = {LANE_SEL_W'(i), lane_res[i].hi};
            end
        end
    end

    always_comb begin
        end_col   = line_end || (cnt_reg >= LAST_COL);
        brk       = open_reg && !link;
        cont      = open_reg && link;
        open_mid  = cont || any;
        start_mid = cont ? start_reg : cnt_reg;
        top_mid   = (cont && top_reg < t_row) ? top_reg : t_row;
        bot_mid   = (cont && bot_reg > b_row) ? bot_reg : b_row;

        box_brk.box_start  = to_box_col(start_reg);
        box_brk.box_end    = to_box_col(cnt_reg - CNT_W'(1));
        box_brk.box_top    = top_reg;
        box_brk.box_bottom = bot_reg;
        box_brk.run_last   = !(end_col && open_mid);

        box_end.box_start  = to_box_col(start_mid);
        box_end.box_end    = to_box_col(cnt_reg);
        box_end.box_top    = top_mid;
        box_end.box_bottom = bot_mid;
        box_end.run_last   = 1'b1;

        e0     = brk ? box_brk : box_end;
        e1     = box_end;
        n_push = 2'(brk) + 2'(end_col && open_mid);
        if (!in_fire) begin
            n_push = '0;
        end

        open_next  = open_reg;
        start_next = start_reg;
        top_next   = top_reg;
        bot_next   = bot_reg;
        cnt_next   = cnt_reg;
        prev_next  = prev_reg;
        if (in_fire) begin
            start_next = start_mid;
            top_next   = top_mid;
            bot_next   = bot_mid;
            if (end_col) begin
                open_next = 1'b0;
                cnt_next  = '0;
                prev_next = '0;
            end else begin
                open_next = open_mid;
                cnt_next  = cnt_reg + CNT_W'(1);
                prev_next = col;
            end
        end

        wptr_next = wptr_reg + PTR_W'(n_push);
        rptr_next = rptr_reg + PTR_W'(m_fire);
        qcnt_next = qcnt_reg + QCNT_W'(n_push) - QCNT_W'(m_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg  <= 1'b0;
            start_reg <= '0;
            top_reg   <= '0;
            bot_reg   <= '0;
            cnt_reg   <= '0;
            prev_reg  <= '0;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            qcnt_reg  <= '0;
        end else begin
            open_reg  <= open_next;
            start_reg <= start_next;
            top_reg   <= top_next;
            bot_reg   <= bot_next;
            cnt_reg   <= cnt_next;
            prev_reg  <= prev_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            qcnt_reg  <= qcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            queue_reg[wptr_reg] <= e0;
        end
        if (n_push == 2'd2) begin
            queue_reg[wptr_reg + PTR_W'(1)] <= e1;
        end
    end

    a_qcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qcnt_reg <= QCNT_W'(DEPTH))
        else $error("result queue overfilled");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && end_col |=> cnt_reg == '0 && !open_reg && prev_reg == '0)
        else $error("line end did not restart the line state");

    a_break_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && brk |=> qcnt_reg != '0)
        else $error("broken link produced no box");

    a_idle_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_fire && !m_fire |=> $stable(qcnt_reg) && $stable(cnt_reg))
        else $error("state moved without a handshake");

endmodule

@@ hdl/column_component_segmenter_top.sv @@
// A column's boxes are written into the result queue as the column is accepted.
// Throughput: one column per cycle while the result queue has room;
// the four-entry result queue takes new columns while it has room for two boxes.
// Each column is resolved combinationally by eight 8-row lanes and a merge step.
// Reset (aresetn low, synchronous) closes any box, clears the column count, the stored
// previous column and the result queue, and sets rows_used to 64.
module column_component_segmenter_top
    import ccs_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] rows_used_reg, rows_used_next;
    logic [CFG_W-1:0] rows_eff;
    logic [COL_W-1:0] mask;
    logic [COL_W-1:0] col_m;
    logic [COL_W-1:0] prev_col;
    logic [COL_W-1:0] prev_m;
    logic             cfg_wr;
    lane_res_t        lane_res [LANES];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ROWS_USED);
    assign prdata = (paddr[2] == REG_ROWS_USED) ? APB_DATA_W'(rows_used_reg) : '0;

    always_comb begin
        rows_used_next = rows_used_reg;
        if (cfg_wr) begin
            rows_used_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_used_reg <= ROWS_USED_RESET;
        end else begin
            rows_used_reg <= rows_used_next;
        end
    end

    // Row count is clamped to MAX_ROWS; rows at or above it read as white.
    always_comb begin
        rows_eff = (rows_used_reg > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_used_reg;
        for (int r = 0; r < COL_W; r++) begin
            mask[r] = CFG_W'(r) < rows_eff;
        end
    end

    assign col_m  = s_data.col_bits & mask;
    assign prev_m = prev_col & mask;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        logic below, above;
        if (i == 0) begin : g_lo
            assign below = 1'b0;
        end else begin : g_lo
            assign below = col_m[i*LANE_W-1];
        end
        if (i == LANES - 1) begin : g_hi
            assign above = 1'b0;
        end else begin : g_hi
            assign above = col_m[(i+1)*LANE_W];
        end
        ccs_lane u_lane (
            .col_seg   (col_m[i*LANE_W +: LANE_W]),
            .prev_seg  (prev_m[i*LANE_W +: LANE_W]),
            .col_below (below),
            .col_above (above),
            .res       (lane_res[i])
        );
    end

    ccs_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .line_end (s_data.line_end),
        .col      (col_m),
        .lane_res (lane_res),
        .prev_col (prev_col),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ verif/box_checker.sv @@
module box_checker
    import ccs_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the block's segmentation state.
    logic [CFG_W-1:0]     rows_cfg;
    logic                 seg_open;
    logic [BOX_COL_W-1:0] seg_start;
    logic [ROW_W-1:0]     seg_top;
    logic [ROW_W-1:0]     seg_bottom;
    int                   col_index;
    logic [COL_W-1:0]     prev_col;

    out_item_t expected_boxes[$];
    out_item_t want;

    function automatic logic [COL_W-1:0] rows_mask(logic [CFG_W-1:0] rows);
        int n;
        n = rows;
        if (n > MAX_ROWS) n = MAX_ROWS;
        if (n >= COL_W) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic logic [ROW_W-1:0] first_black(logic [COL_W-1:0] c);
        for (int r = 0; r < COL_W; r++) begin
            if (c[r]) return ROW_W'(r);
        end
        return ROW_W'(COL_W - 1);
    endfunction

    function automatic logic [ROW_W-1:0] last_black(logic [COL_W-1:0] c);
        for (int r = COL_W - 1; r >= 0; r--) begin
            if (c[r]) return ROW_W'(r);
        end
        return '0;
    endfunction

    function automatic out_item_t box_of(int first_col, int last_col);
        out_item_t b;
        b.box_start  = BOX_COL_W'(first_col);
        b.box_end    = BOX_COL_W'(last_col);
        b.box_top    = seg_top;
        b.box_bottom = seg_bottom;
        b.run_last   = 1'b0;
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
        $display("%0t: box mismatch on %s: got %0h, expected %0h", $realtime, what, got,
                 exp_v);
        errors++;
    endtask

    // Works out the boxes closed by one column and appends them to expected_boxes.
    task automatic predict_boxes(in_item_t it);
        logic [COL_W-1:0] mask;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] near;
        logic             closing;
        logic [ROW_W-1:0] t;
        logic [ROW_W-1:0] b;
        out_item_t        boxes[2];
        int               n;
        mask    = rows_mask(rows_cfg);
        col     = it.col_bits & mask;
        closing = it.line_end || (col_index >= MAX_COLUMNS - 1);
        n       = 0;
        if (seg_open) begin
            near = col | (col << 1) | (col >> 1);
            if ((prev_col & mask & near) == '0) begin
                boxes[n] = box_of(seg_start, col_index - 1);
                n++;
                seg_open = 1'b0;
            end else begin
                t = first_black(col);
                b = last_black(col);
                if (t < seg_top) seg_top = t;
                if (b > seg_bottom) seg_bottom = b;
            end
        end
        if (!seg_open && col != '0) begin
            seg_open   = 1'b1;
            seg_start  = BOX_COL_W'(col_index);
            seg_top    = first_black(col);
            seg_bottom = last_black(col);
        end
        if (closing) begin
            if (seg_open) begin
                boxes[n] = box_of(seg_start, col_index);
                n++;
            end
            seg_open  = 1'b0;
            col_index = 0;
            prev_col  = '0;
        end else begin
            col_index++;
            prev_col = col;
        end
        if (n > 0) boxes[n-1].run_last = 1'b1;
        for (int k = 0; k < n; k++) expected_boxes.push_back(boxes[k]);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg   = ROWS_USED_RESET;
            seg_open   = 1'b0;
            seg_start  = '0;
            seg_top    = '0;
            seg_bottom = '0;
            col_index  = 0;
            prev_col   = '0;
            errors     = 0;
            expected_boxes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_boxes.size() == 0) begin
                    report_mismatch("unexpected box", 64'(m_data), '0);
                end else begin
                    want = expected_boxes.pop_front();
                    if (m_data.box_start !== want.box_start)
                        report_mismatch("box_start", m_data.box_start, want.box_start);
                    if (m_data.box_end !== want.box_end)
                        report_mismatch("box_end", m_data.box_end, want.box_end);
                    if (m_data.box_top !== want.box_top)
                        report_mismatch("box_top", m_data.box_top, want.box_top);
                    if (m_data.box_bottom !== want.box_bottom)
                        report_mismatch("box_bottom", m_data.box_bottom, want.box_bottom);
                    if (m_data.run_last !== want.run_last)
                        report_mismatch("run_last", m_data.run_last, want.run_last);
                end
            end
            // A column taken at the same edge as a register write still sees the old mask.
            if (s_valid && s_ready) predict_boxes(s_data);
            if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1] == REG_ROWS_USED)
                rows_cfg = pwdata[CFG_W-1:0];
        end
        pending = expected_boxes.size();
    end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    import ccs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS     = DEF_MAX_ROWS;
    localparam int MAX_COLUMNS  = DEF_MAX_COLUMNS;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE       = 4;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 125;

    localparam logic [APB_ADDR_W-1:0] ROWS_USED_ADDR = {REG_ROWS_USED, 2'b00};

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    int rows_now;
    int stall_cycles;
    logic [COL_W-1:0] shape;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    column_component_segmenter_top #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLUMNS(MAX_COLUMNS)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    box_checker #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_box_checker (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .pready (pready),
        .errors (errors),
        .pending(pending)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Column shapes: blanks, strokes that drift by at most one row from the last
    // shape, solid bands of rows, and pure noise.
    function automatic logic [COL_W-1:0] next_column();
        int span;
        int lo;
        int hi;
        int pick;
        logic [COL_W-1:0] c;
        pick = $urandom_range(99);
        span = (rows_now >= 1 && rows_now < COL_W) ? rows_now : COL_W;
        if (pick < 25) begin
            c = '0;
        end else if (pick < 60 && shape != '0) begin
            case ($urandom_range(2))
                0: c = shape << 1;
                1: c = shape >> 1;
                default: c = shape;
            endcase
            if ($urandom_range(3) == 0) c = c & {$urandom(), $urandom()};
        end else if (pick < 90) begin
            lo = $urandom_range(span - 1, 0);
            hi = $urandom_range(span - 1, lo);
            c  = (hi - lo + 1 >= COL_W) ? '1 : ((64'd1 << (hi - lo + 1)) - 64'd1) << lo;
        end else begin
            c = {$urandom(), $urandom()};
        end
        if (c != '0) shape = c;
        return c;
    endfunction

    task automatic send_column(logic [COL_W-1:0] bits, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{col_bits: bits, line_end: last};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_rows(int rows);
        logic [APB_DATA_W-1:0] d;
        d = $urandom();
        d[CFG_W-1:0] = CFG_W'(rows);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ROWS_USED_ADDR;
        pwdata  <= d;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rows_now = rows;
    endtask

    // Stops the column stream and waits until every expected box has come out.
    task automatic drain_boxes();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        int rows_plan[PHASES];
        rows_plan = '{1, 0, 127, 2, 65, 0, 100, 64};
        rows_plan[5] = $urandom_range(63, 3);
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        tx_idle_pct = 17;
        rx_idle_pct = 75;
        rows_now    = 64;
        shape       = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Full and empty columns, diagonal links both ways, a broken link and a
        // line end in the same column, an empty line end and a one-column line.
        send_column('1, 1'b0);
        send_column('0, 1'b0);
        send_column(64'h8000_0000_0000_0000, 1'b0);
        send_column(64'h4000_0000_0000_0000, 1'b0);
        send_column(64'h8000_0000_0000_0000, 1'b0);
        send_column(64'h0000_0000_0000_0001, 1'b1);
        send_column('0, 1'b1);
        send_column(64'h0000_0000_0000_0020, 1'b1);
        send_column(64'h5555_5555_5555_5555, 1'b0);
        send_column(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_column(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_column(64'h8000_0000_0000_0001, 1'b0);
        send_column(64'h0000_0000_0000_0003, 1'b0);
        drain_boxes();

        // The line is usually still open when a phase ends, so each new row
        // count also lands in the middle of a line.
        for (int p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                tx_idle_pct = 17;
                rx_idle_pct = 75;
            end else if (p < 6) begin
                tx_idle_pct = 75;
                rx_idle_pct = 17;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_rows(rows_plan[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_column(next_column(), $urandom_range(29) == 0);
            drain_boxes();
        end

        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ccs_pkg.sv
hdl/ccs_lane.sv
hdl/ccs_ctrl.sv
hdl/column_component_segmenter_top.sv
verif/box_checker.sv
verif/tb_top.sv
